>>> sv/cre_pkg.sv
package cre_pkg;

	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] DASH_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;

	// Character classes that can bound a range
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_UPPER = 2'd1,
		CLS_LOWER = 2'd2,
		CLS_DIGIT = 2'd3
	} char_class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DASH,
		ST_CHAR,
		ST_TAIL
	} state_t;

	// What the output register is loaded with
	typedef enum logic [1:0] {
		EMIT_RUN,
		EMIT_DASH,
		EMIT_CHAR,
		EMIT_TAIL
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      emit;
		emit_sel_t sel;
	} cre_cmd_t;

	typedef struct packed {
		logic plan_run;
		logic plan_dash;
		logic plan_char;
		logic plan_tail;
		logic need_char;
		logic need_tail;
		logic run_done;
		logic out_free;
	} cre_sts_t;

	function automatic char_class_t char_class(input logic [CHAR_W-1:0] c);
		char_class_t r;
		r = CLS_NONE;
		if (c >= 8'h41 && c <= 8'h5A) r = CLS_UPPER;
		else if (c >= 8'h61 && c <= 8'h7A) r = CLS_LOWER;
		else if (c >= 8'h30 && c <= 8'h39) r = CLS_DIGIT;
		return r;
	endfunction

endpackage

>>> sv/cre_datapath.sv
module cre_datapath import cre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cre_cmd_t          cmd,
	output cre_sts_t          sts,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_run_last,
	output logic              out_string_end
);

	// String context
	logic              at_start_q;
	logic              pending_q;
	logic [CHAR_W-1:0] prev_q;
	logic [CHAR_W-1:0] start_q;

	// Item in work
	logic [CHAR_W-1:0] ch_q;
	logic [CHAR_W-1:0] cnt_q;
	logic              ends_q;
	logic              need_char_q;
	logic              need_tail_q;

	// Output register
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              end_q;

	logic              nonnul;
	logic              ends;
	logic              mid;
	logic              range_ok;
	logic              pend_after;
	char_class_t       cls_ch;
	logic [CHAR_W:0]   start_inc;
	logic [CHAR_W-1:0] emit_char;
	logic              emit_last;

	always_comb begin
		nonnul     = (in_char != NUL_CHAR);
		ends       = in_last || !nonnul;
		mid        = nonnul && !at_start_q;
		cls_ch     = char_class(in_char);
		range_ok   = (cls_ch != CLS_NONE) && (cls_ch == char_class(start_q))
		             && (in_char > start_q);
		start_inc  = {1'b0, start_q} + {{CHAR_W{1'b0}}, 1'b1};
		pend_after = mid ? (in_char == DASH_CHAR) : pending_q;

		sts.plan_run  = mid && pending_q && range_ok && ({1'b0, in_char} > start_inc);
		sts.plan_dash = mid && pending_q && !range_ok;
		sts.plan_char = nonnul && (at_start_q || in_char != DASH_CHAR);
		sts.plan_tail = ends && pend_after;
		sts.need_char = need_char_q;
		sts.need_tail = need_tail_q;
		sts.run_done  = (cnt_q + 8'd1) == ch_q;
		sts.out_free  = !valid_q || out_ready;
	end

	// Result mux: a run char is never last, since the closing char always follows
	always_comb begin
		unique case (cmd.sel)
			EMIT_RUN: begin
				emit_char = cnt_q;
				emit_last = 1'b0;
			end
			EMIT_DASH: begin
				emit_char = DASH_CHAR;
				emit_last = !need_char_q && !need_tail_q;
			end
			EMIT_CHAR: begin
				emit_char = ch_q;
				emit_last = !need_tail_q;
			end
			EMIT_TAIL: begin
				emit_char = DASH_CHAR;
				emit_last = 1'b1;
			end
			default: begin
				emit_char = DASH_CHAR;
				emit_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			pending_q  <= 1'b0;
			prev_q     <= NUL_CHAR;
			start_q    <= NUL_CHAR;
		end else if (cmd.accept) begin
			if (nonnul) begin
				prev_q <= in_char;
				if (at_start_q) begin
					at_start_q <= 1'b0;
				end else begin
					pending_q <= (in_char == DASH_CHAR);
					if (in_char == DASH_CHAR) start_q <= prev_q;
				end
			end
			if (ends) begin
				at_start_q <= 1'b1;
				pending_q  <= 1'b0;
				prev_q     <= NUL_CHAR;
				start_q    <= NUL_CHAR;
			end
		end
	end

	// Item registers: latch on accept, step the run counter on each run char
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q        <= in_char;
			cnt_q       <= start_inc[CHAR_W-1:0];
			ends_q      <= ends;
			need_char_q <= sts.plan_char;
			need_tail_q <= sts.plan_tail;
		end else if (cmd.emit && cmd.sel == EMIT_RUN) begin
			cnt_q <= cnt_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
			end_q  <= emit_last && ends_q;
		end
	end

	assign out_valid      = valid_q;
	assign out_char       = char_q;
	assign out_run_last   = last_q;
	assign out_string_end = end_q;

endmodule

>>> sv/cre_ctrl.sv
module cre_ctrl import cre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cre_sts_t sts,
	output cre_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.plan_run) state_d = ST_RUN;
					else if (sts.plan_dash) state_d = ST_DASH;
					else if (sts.plan_char) state_d = ST_CHAR;
					else if (sts.plan_tail) state_d = ST_TAIL;
				end
			end
			ST_RUN: begin
				if (sts.out_free && sts.run_done) state_d = ST_CHAR;
			end
			ST_DASH: begin
				if (sts.out_free) begin
					if (sts.need_char) state_d = ST_CHAR;
					else if (sts.need_tail) state_d = ST_TAIL;
					else state_d = ST_IDLE;
				end
			end
			ST_CHAR: begin
				if (sts.out_free) state_d = sts.need_tail ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.emit   = 1'b0;
		cmd.sel    = EMIT_CHAR;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RUN: begin
				cmd.emit = sts.out_free;
				cmd.sel  = EMIT_RUN;
			end
			ST_DASH: begin
				cmd.emit = sts.out_free;
				cmd.sel  = EMIT_DASH;
			end
			ST_CHAR: begin
				cmd.emit = sts.out_free;
				cmd.sel  = EMIT_CHAR;
			end
			ST_TAIL: begin
				cmd.emit = sts.out_free;
				cmd.sel  = EMIT_TAIL;
			end
			default: ;
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded into a full output register");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (state_q == ST_IDLE && !cmd.emit))
		else $error("request taken while an item is in work");

	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |=> (state_q == ST_RUN || state_q == ST_CHAR))
		else $error("run left without its closing character");

	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL && sts.out_free) |=> state_q == ST_IDLE)
		else $error("trailing dash did not end the item");

endmodule

>>> sv/character_range_expander.sv
// Channel  | Direction | Signals                       | Contents
// ---------+-----------+-------------------------------+----------------------------------
// s_*      | in        | s_tvalid s_tready s_tdata     | tdata[7:0] in_char
//          |           | s_tlast                       | tlast in_last
// m_*      | out       | m_tvalid m_tready m_tdata     | tdata[7:0] out_char
//          |           | m_tlast m_tuser               | tlast run_last, tuser[0] string_end
//
// Flow: a request is taken while idle, then its results leave one per cycle while
//   m_tready does not stall, through the single output register; s_tready stays
//   low until the item's last result is loaded into that register.
// Reset: arst_n clears the controller, the string context and the output valid.
// Stalls: a held m_tready freezes emission; the output register lets a request
//   be taken while the last result of the previous one still waits.
module character_range_expander import cre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
	input  logic              s_tlast,   // in_last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
	output logic              m_tlast,   // run_last
	output logic [0:0]        m_tuser    // [0] string_end
);

	cre_cmd_t cmd;
	cre_sts_t sts;
	logic     string_end;

	// Sequence each item: an optional run or copied dash, the char itself and a trailing dash, each only if planned
	cre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold string context, plan each item on accept, drive the output register
	cre_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_char        (s_tdata),
		.in_last        (s_tlast),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_char       (m_tdata),
		.out_run_last   (m_tlast),
		.out_string_end (string_end)
	);

	assign m_tuser = string_end;

endmodule
